// ===== sv/pdts_pkg.sv =====
package pdts_pkg;

    // image range and period limits
    localparam int MAX_IMAGE_RANGE = 8;
    localparam int MAX_PERIOD      = 256;

    // configuration port
    localparam int CFG_W = 48;
    localparam int IDX_W = 3;
    localparam logic [IDX_W-1:0] REG_LATTICE_A = 3'd0;
    localparam logic [IDX_W-1:0] REG_LATTICE_B = 3'd1;
    localparam logic [IDX_W-1:0] REG_LATTICE_C = 3'd2;
    localparam logic [IDX_W-1:0] REG_WIDTH     = 3'd3;
    localparam logic [IDX_W-1:0] REG_DEPTH     = 3'd4;
    localparam logic [IDX_W-1:0] REG_CUTOFF    = 3'd5;

    // field widths
    localparam int PER_W  = 9;
    localparam int CUT_W  = 12;
    localparam int OFF_W  = 8;
    localparam int OFFC_W = 9;
    localparam int COMP_W = 16;
    localparam int OUT_W  = 32;

    // datapath widths
    localparam int RNG_W  = $clog2(MAX_IMAGE_RANGE + 1);
    localparam int IMG_W  = RNG_W + 1;
    localparam int CA_W   = IMG_W + PER_W + 2;
    localparam int PROD_W = CA_W + COMP_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int MAG_W  = 31;
    localparam int H_W    = 5;
    localparam int QUO_W  = 32;
    localparam int COEF_W = 34;
    localparam int TERM_W = 36;
    localparam int ACC_W  = TERM_W + 2 * IMG_W;

    // root and divider pipelines
    localparam int STEPS_PER_STG = 2;
    localparam int SQ_STEPS      = 32;
    localparam int SQ_STG        = SQ_STEPS / STEPS_PER_STG;
    localparam int DIV_STEPS     = QUO_W;
    localparam int DIV_STG       = DIV_STEPS / STEPS_PER_STG;

    // tensor element index pairs, xx xy xz yy yz zz
    localparam int PAIR_P [6] = '{0, 0, 0, 1, 1, 2};
    localparam int PAIR_Q [6] = '{0, 1, 2, 1, 2, 2};

    typedef struct packed {
        logic vld;
        logic last;
    } t_ctl;

    typedef struct packed {
        logic                      zero;
        logic [2:0]                neg;
        logic [H_W-1:0]            h;
        logic [2:0][MAG_W-1:0]     mag;
    } t_geo;

    typedef struct packed {
        logic           zero;
        logic [2:0]     neg;
        logic [H_W-1:0] h;
    } t_sgn;

    typedef struct packed {
        logic [63:0] m;
        logic [63:0] res;
    } t_sq;

    typedef struct packed {
        logic [31:0]      rem;
        logic [31:0]      lo;
        logic [31:0]      den;
        logic [QUO_W-1:0] q;
    } t_dvs;

    function automatic logic [PER_W-1:0] period_of(input logic [PER_W-1:0] v);
        logic [PER_W-1:0] p;
        p = v;
        if (v == '0) p = PER_W'(1);
        else if (v > MAX_PERIOD) p = PER_W'(MAX_PERIOD);
        return p;
    endfunction

    // image range: count of multiples of the smaller period within the cutoff
    function automatic logic [RNG_W-1:0] range_of(input logic [CUT_W-1:0] cut,
                                                  input logic [PER_W-1:0] mn);
        logic [RNG_W-1:0] cnt;
        cnt = '0;
        for (int k = 1; k <= MAX_IMAGE_RANGE; k++) begin
            if (32'(k) * 32'(mn) <= 32'(cut)) cnt = cnt + RNG_W'(1);
        end
        return cnt;
    endfunction

    // shift count in pairs of bits so that the value reaches bit 62 or 63
    function automatic logic [H_W-1:0] norm_shift(input logic [63:0] v);
        logic [5:0] p;
        p = '0;
        for (int b = 0; b < 64; b++) begin
            if (v[b]) p = 6'(b);
        end
        return H_W'((6'd63 - p) >> 1);
    endfunction

    function automatic t_sq sqrt_step(input t_sq x, input int k);
        logic [63:0] bitv;
        logic [63:0] trial;
        t_sq         y;
        bitv  = 64'd1 << (62 - 2 * k);
        trial = x.res + bitv;
        if (x.m >= trial) begin
            y.m   = x.m - trial;
            y.res = (x.res >> 1) + bitv;
        end else begin
            y.m   = x.m;
            y.res = x.res >> 1;
        end
        return y;
    endfunction

    function automatic t_dvs div_step(input t_dvs x);
        logic [32:0] t;
        t_dvs        y;
        t = {x.rem, x.lo[31]};
        y = x;
        y.lo = x.lo << 1;
        if (t >= {1'b0, x.den}) begin
            y.rem = 32'(t - {1'b0, x.den});
            y.q   = {x.q[QUO_W-2:0], 1'b1};
        end else begin
            y.rem = t[31:0];
            y.q   = {x.q[QUO_W-2:0], 1'b0};
        end
        return y;
    endfunction

endpackage

// ===== sv/pdts_isqrt.sv =====
// pipelined integer square root, two result bits per stage
module pdts_isqrt import pdts_pkg::*; (
    input  logic        i_clk,
    input  logic [63:0] i_m,
    output logic [31:0] o_root
);

    t_sq r_stg [SQ_STG];

    for (genvar g = 0; g < SQ_STG; g++) begin : g_stg
        t_sq src;
        t_sq n_stg;
        if (g == 0) begin : g_first
            assign src = '{m: i_m, res: 64'd0};
        end else begin : g_next
            assign src = r_stg[g-1];
        end
        always_comb begin
            n_stg = src;
            for (int t = 0; t < STEPS_PER_STG; t++) begin
                n_stg = sqrt_step(n_stg, g * STEPS_PER_STG + t);
            end
        end
        always_ff @(posedge i_clk) begin
            r_stg[g] <= n_stg;
        end
    end

    assign o_root = r_stg[SQ_STG-1].res[31:0];

endmodule

// ===== sv/pdts_div.sv =====
// pipelined restoring divider, quotient must fit in QUO_W bits
module pdts_div import pdts_pkg::*; (
    input  logic             i_clk,
    input  logic [63:0]      i_num,
    input  logic [31:0]      i_den,
    output logic [QUO_W-1:0] o_quo
);

    t_dvs r_stg [DIV_STG];

    for (genvar g = 0; g < DIV_STG; g++) begin : g_stg
        t_dvs src;
        t_dvs n_stg;
        if (g == 0) begin : g_first
            assign src = '{rem: i_num[63:32], lo: i_num[31:0], den: i_den, q: '0};
        end else begin : g_next
            assign src = r_stg[g-1];
        end
        always_comb begin
            n_stg = src;
            for (int t = 0; t < STEPS_PER_STG; t++) begin
                n_stg = div_step(n_stg);
            end
        end
        always_ff @(posedge i_clk) begin
            r_stg[g] <= n_stg;
        end
    end

    assign o_quo = r_stg[DIV_STG-1].q;

endmodule

// ===== sv/periodic_dipole_tensor_sum.sv =====
// throughput: the image pipeline takes one image per cycle while an item runs; a new item
//   starts only once the previous one has left the pipeline and the result register is free
// at the largest image range (s = 8) an item covers 289 images
// reset: synchronous, active low; registers return to the unit lattice, periods of 32
//   and zero cutoff, the sequencer goes idle and the result register empties
module periodic_dipole_tensor_sum import pdts_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration writes
    input  logic              i_cfg_we,
    input  logic [IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    // input stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [31:0]       s_axis_tdata,   // off_a [7:0], off_b [15:8], off_c [24:16]
    // result stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [191:0]      m_axis_tdata    // t_xx, t_xy, t_xz, t_yy, t_yz, t_zz, 32 bit each
);

    localparam logic signed [ACC_W-1:0]  ACC_HI  = ACC_W'(64'sh7FFF_FFFF);
    localparam logic signed [ACC_W-1:0]  ACC_LO  = ACC_W'(-64'sh8000_0000);
    localparam logic signed [COEF_W-1:0] ONE_Q30 = COEF_W'(64'sd1073741824);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WAIT = 3'b010,
        ST_RUN  = 3'b100
    } t_state;

    // ---------------------------------------------------------------- configuration
    logic [CFG_W-1:0] r_lat_a, r_lat_b, r_lat_c;
    logic [PER_W-1:0] r_width, r_depth;
    logic [CUT_W-1:0] r_cutoff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lat_a  <= CFG_W'(48'h0000_0000_1000);
            r_lat_b  <= CFG_W'(48'h0000_1000_0000);
            r_lat_c  <= CFG_W'(48'h1000_0000_0000);
            r_width  <= PER_W'(32);
            r_depth  <= PER_W'(32);
            r_cutoff <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LATTICE_A: r_lat_a  <= i_cfg_data;
                REG_LATTICE_B: r_lat_b  <= i_cfg_data;
                REG_LATTICE_C: r_lat_c  <= i_cfg_data;
                REG_WIDTH:     r_width  <= i_cfg_data[PER_W-1:0];
                REG_DEPTH:     r_depth  <= i_cfg_data[PER_W-1:0];
                REG_CUTOFF:    r_cutoff <= i_cfg_data[CUT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    logic [PER_W-1:0] per_w, per_d, per_min;
    logic signed [COMP_W-1:0] comp_a [3];
    logic signed [COMP_W-1:0] comp_b [3];
    logic signed [COMP_W-1:0] comp_c [3];

    always_comb begin
        per_w   = period_of(r_width);
        per_d   = period_of(r_depth);
        per_min = (per_w < per_d) ? per_w : per_d;
        for (int k = 0; k < 3; k++) begin
            comp_a[k] = $signed(r_lat_a[16*k +: 16]);
            comp_b[k] = $signed(r_lat_b[16*k +: 16]);
            comp_c[k] = $signed(r_lat_c[16*k +: 16]);
        end
    end

    // ---------------------------------------------------------------- image sequencer
    t_state                    r_state, n_state;
    logic signed [IMG_W-1:0]   r_i, n_i, r_j, n_j;
    logic [RNG_W-1:0]          r_s;
    logic [OFF_W-1:0]          r_ia, r_ib;
    logic signed [OFFC_W-1:0]  r_ic;
    logic                      r_inflight, n_inflight;
    logic                      r_out_vld, n_out_vld;
    logic signed [IMG_W-1:0]   s_sg;
    logic                      seq_run, seq_last;
    t_ctl                      r_e4_ctl;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_sg          = $signed({1'b0, r_s});
    assign seq_run       = (r_state == ST_RUN);
    assign seq_last      = seq_run && (r_i == s_sg) && (r_j == s_sg);

    always_comb begin
        n_state    = r_state;
        n_i        = r_i;
        n_j        = r_j;
        n_inflight = r_inflight;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) n_state = ST_WAIT;
            end
            // start only when the pipeline is empty and the result register is free
            ST_WAIT: begin
                if (!r_inflight && (!r_out_vld || m_axis_tready)) begin
                    n_state = ST_RUN;
                    n_i     = -s_sg;
                    n_j     = -s_sg;
                end
            end
            ST_RUN: begin
                if (seq_last) begin
                    n_state    = ST_IDLE;
                    n_inflight = 1'b1;
                end else if (r_i == s_sg) begin
                    n_i = -s_sg;
                    n_j = r_j + IMG_W'(1);
                end else begin
                    n_i = r_i + IMG_W'(1);
                end
            end
            default: n_state = ST_IDLE;
        endcase
        if (r_e4_ctl.vld && r_e4_ctl.last) n_inflight = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_inflight <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_inflight <= n_inflight;
        end
        r_i <= n_i;
        r_j <= n_j;
        if (s_axis_tvalid && s_axis_tready) begin
            r_ia <= s_axis_tdata[7:0];
            r_ib <= s_axis_tdata[15:8];
            r_ic <= $signed(s_axis_tdata[24:16]);
            r_s  <= range_of(r_cutoff, per_min);
        end
    end

    // ---------------------------------------------------------------- stage 1: cell coordinates
    t_ctl                     r_s1_ctl;
    logic signed [CA_W-1:0]   r_s1_ca, r_s1_cb;
    logic signed [OFFC_W-1:0] r_s1_ic;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s1_ctl <= '0;
        else          r_s1_ctl <= '{vld: seq_run, last: seq_last};
        r_s1_ca <= CA_W'(r_i) * CA_W'($signed({1'b0, per_w})) + CA_W'($signed({1'b0, r_ia}));
        r_s1_cb <= CA_W'(r_j) * CA_W'($signed({1'b0, per_d})) + CA_W'($signed({1'b0, r_ib}));
        r_s1_ic <= r_ic;
    end

    // ---------------------------------------------------------------- stage 2: lattice products
    t_ctl                     r_s2_ctl;
    logic signed [PROD_W-1:0] r_s2_pa [3];
    logic signed [PROD_W-1:0] r_s2_pb [3];
    logic signed [PROD_W-1:0] r_s2_pc [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s2_ctl <= '0;
        else          r_s2_ctl <= r_s1_ctl;
        for (int k = 0; k < 3; k++) begin
            r_s2_pa[k] <= PROD_W'(r_s1_ca) * PROD_W'(comp_a[k]);
            r_s2_pb[k] <= PROD_W'(r_s1_cb) * PROD_W'(comp_b[k]);
            r_s2_pc[k] <= PROD_W'(r_s1_ic) * PROD_W'(comp_c[k]);
        end
    end

    // ---------------------------------------------------------------- stage 3: displacement
    t_ctl               r_s3_ctl;
    logic signed [31:0] r_s3_r [3];
    logic signed [31:0] n_s3_r [3];

    always_comb begin
        logic signed [SUM_W-1:0] sum;
        logic signed [63:0]      s64;
        for (int k = 0; k < 3; k++) begin
            sum = SUM_W'(r_s2_pa[k]) + SUM_W'(r_s2_pb[k]) + SUM_W'(r_s2_pc[k]);
            s64 = 64'(sum);
            if (s64 > 64'sh7FFF_FFFF)       n_s3_r[k] = 32'sh7FFF_FFFF;
            else if (s64 < -64'sh7FFF_FFFF) n_s3_r[k] = -32'sh7FFF_FFFF;
            else                            n_s3_r[k] = 32'(s64);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s3_ctl <= '0;
        else          r_s3_ctl <= r_s2_ctl;
        r_s3_r <= n_s3_r;
    end

    // ---------------------------------------------------------------- stage 4: magnitudes, squares
    t_ctl              r_s4_ctl;
    logic [2:0]        r_s4_neg;
    logic [MAG_W-1:0]  r_s4_mag [3];
    logic [63:0]       r_s4_sq  [3];
    logic [MAG_W-1:0]  n_s4_mag [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_s4_mag[k] = MAG_W'(r_s3_r[k][31] ? -r_s3_r[k] : r_s3_r[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s4_ctl <= '0;
        else          r_s4_ctl <= r_s3_ctl;
        for (int k = 0; k < 3; k++) begin
            r_s4_neg[k] <= r_s3_r[k][31];
            r_s4_mag[k] <= n_s4_mag[k];
            r_s4_sq[k]  <= 64'(n_s4_mag[k]) * 64'(n_s4_mag[k]);
        end
    end

    // ---------------------------------------------------------------- stage 5: squared length
    t_ctl        r_s5_ctl;
    t_geo        r_s5_geo, n_s5_geo;
    logic [63:0] r_s5_r2, n_s5_r2;

    always_comb begin
        n_s5_r2       = r_s4_sq[0] + r_s4_sq[1] + r_s4_sq[2];
        n_s5_geo.zero = (n_s5_r2 == 64'd0);
        n_s5_geo.neg  = r_s4_neg;
        n_s5_geo.h    = '0;
        for (int k = 0; k < 3; k++) n_s5_geo.mag[k] = r_s4_mag[k];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s5_ctl <= '0;
        else          r_s5_ctl <= r_s4_ctl;
        r_s5_r2  <= n_s5_r2;
        r_s5_geo <= n_s5_geo;
    end

    // ---------------------------------------------------------------- stages 6, 7: normalise
    t_ctl        r_s6_ctl, r_s7_ctl;
    t_geo        r_s6_geo, r_s7_geo;
    logic [63:0] r_s6_r2, r_s7_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_ctl <= '0;
            r_s7_ctl <= '0;
        end else begin
            r_s6_ctl <= r_s5_ctl;
            r_s7_ctl <= r_s6_ctl;
        end
        r_s6_r2  <= r_s5_r2;
        r_s6_geo <= '{zero: r_s5_geo.zero, neg: r_s5_geo.neg,
                      h: norm_shift(r_s5_r2), mag: r_s5_geo.mag};
        r_s7_m   <= r_s6_r2 << {r_s6_geo.h, 1'b0};
        r_s7_geo <= r_s6_geo;
    end

    // ---------------------------------------------------------------- square root
    logic [31:0] sq_root;
    t_ctl        r_sq_ctl [SQ_STG];
    t_geo        r_sq_geo [SQ_STG];

    pdts_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_m    (r_s7_m),
        .o_root (sq_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < SQ_STG; g++) r_sq_ctl[g] <= '0;
        end else begin
            r_sq_ctl[0] <= r_s7_ctl;
            for (int g = 1; g < SQ_STG; g++) r_sq_ctl[g] <= r_sq_ctl[g-1];
        end
        r_sq_geo[0] <= r_s7_geo;
        for (int g = 1; g < SQ_STG; g++) r_sq_geo[g] <= r_sq_geo[g-1];
    end

    // ---------------------------------------------------------------- dividends
    t_ctl        r_p_ctl;
    t_sgn        r_p_sgn;
    logic [63:0] r_p_num [4];
    logic [31:0] r_p_den;
    t_geo        sq_geo;

    assign sq_geo = r_sq_geo[SQ_STG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_p_ctl <= '0;
        else          r_p_ctl <= r_sq_ctl[SQ_STG-1];
        r_p_sgn <= '{zero: sq_geo.zero, neg: sq_geo.neg, h: sq_geo.h};
        for (int k = 0; k < 3; k++) begin
            r_p_num[k] <= (64'(sq_geo.mag[k]) << sq_geo.h) << 30;
        end
        r_p_num[3] <= 64'h7FFF_FFFF_FFFF_FFFF;
        r_p_den    <= sq_root;
    end

    // ---------------------------------------------------------------- unit vector and 1/|r|
    logic [QUO_W-1:0] quo [4];
    t_ctl             r_dv_ctl [DIV_STG];
    t_sgn             r_dv_sgn [DIV_STG];

    for (genvar k = 0; k < 4; k++) begin : g_div
        pdts_div u_div (
            .i_clk (i_clk),
            .i_num (r_p_num[k]),
            .i_den (r_p_den),
            .o_quo (quo[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < DIV_STG; g++) r_dv_ctl[g] <= '0;
        end else begin
            r_dv_ctl[0] <= r_p_ctl;
            for (int g = 1; g < DIV_STG; g++) r_dv_ctl[g] <= r_dv_ctl[g-1];
        end
        r_dv_sgn[0] <= r_p_sgn;
        for (int g = 1; g < DIV_STG; g++) r_dv_sgn[g] <= r_dv_sgn[g-1];
    end

    // ---------------------------------------------------------------- E1: u products, w^2
    t_ctl               r_e1_ctl;
    t_sgn               r_e1_sgn;
    logic signed [63:0] r_e1_prod [6];
    logic [31:0]        r_e1_w2, r_e1_wi;
    logic signed [32:0] u [3];
    t_sgn               dv_sgn;

    assign dv_sgn = r_dv_sgn[DIV_STG-1];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            u[k] = dv_sgn.neg[k] ? -$signed({1'b0, quo[k]}) : $signed({1'b0, quo[k]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_e1_ctl <= '0;
        else          r_e1_ctl <= r_dv_ctl[DIV_STG-1];
        r_e1_sgn <= dv_sgn;
        for (int k = 0; k < 6; k++) begin
            r_e1_prod[k] <= 64'(u[PAIR_P[k]]) * 64'(u[PAIR_Q[k]]);
        end
        r_e1_w2 <= 32'((64'(quo[3]) * 64'(quo[3])) >> 32);
        r_e1_wi <= quo[3];
    end

    // ---------------------------------------------------------------- E2: coefficients, w^3
    t_ctl                     r_e2_ctl;
    t_sgn                     r_e2_sgn;
    logic signed [COEF_W-1:0] r_e2_coef [6];
    logic signed [COEF_W-1:0] n_e2_coef [6];
    logic [31:0]              r_e2_w3;

    always_comb begin
        logic signed [63:0] tri3;
        for (int k = 0; k < 6; k++) begin
            tri3 = r_e1_prod[k] + (r_e1_prod[k] <<< 1);
            n_e2_coef[k] = COEF_W'(tri3 >>> 30);
            if (PAIR_P[k] == PAIR_Q[k]) n_e2_coef[k] = n_e2_coef[k] - ONE_Q30;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_e2_ctl <= '0;
        else          r_e2_ctl <= r_e1_ctl;
        r_e2_sgn  <= r_e1_sgn;
        r_e2_coef <= n_e2_coef;
        r_e2_w3   <= 32'((64'(r_e1_w2) * 64'(r_e1_wi)) >> 32);
    end

    // ---------------------------------------------------------------- E3: scale 1/|r|^3
    t_ctl                     r_e3_ctl;
    logic                     r_e3_zero;
    logic signed [COEF_W-1:0] r_e3_coef [6];
    logic [30:0]              r_e3_inv3, n_e3_inv3;

    always_comb begin
        logic signed [7:0] sh;
        logic [63:0]       v64;
        sh = $signed(8'(3 * {3'b0, r_e2_sgn.h})) - 8'sd65;
        if (sh >= 8'sd32)     v64 = 64'h7FFF_FFFF;
        else if (sh >= 8'sd0) v64 = 64'(r_e2_w3) << sh;
        else if (-sh >= 8'sd64) v64 = 64'd0;
        else                  v64 = 64'(r_e2_w3) >> (-sh);
        if (v64 > 64'h7FFF_FFFF) n_e3_inv3 = 31'h7FFF_FFFF;
        else                     n_e3_inv3 = v64[30:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_e3_ctl <= '0;
        else          r_e3_ctl <= r_e2_ctl;
        r_e3_zero <= r_e2_sgn.zero;
        r_e3_coef <= r_e2_coef;
        r_e3_inv3 <= n_e3_inv3;
    end

    // ---------------------------------------------------------------- E4: tensor terms
    logic signed [TERM_W-1:0] r_e4_term [6];
    logic signed [TERM_W-1:0] n_e4_term [6];

    always_comb begin
        logic signed [65:0] prd;
        for (int k = 0; k < 6; k++) begin
            prd = r_e3_coef[k] * $signed({1'b0, r_e3_inv3});
            // coinciding image adds nothing
            n_e4_term[k] = r_e3_zero ? '0 : TERM_W'(prd >>> 30);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_e4_ctl <= '0;
        else          r_e4_ctl <= r_e3_ctl;
        r_e4_term <= n_e4_term;
    end

    // ---------------------------------------------------------------- accumulate and saturate
    logic signed [ACC_W-1:0] r_acc [6];
    logic signed [ACC_W-1:0] n_sum [6];
    logic [OUT_W-1:0]        n_sat [6];
    logic [OUT_W-1:0]        r_out [6];

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            n_sum[k] = r_acc[k] + ACC_W'(r_e4_term[k]);
            if (n_sum[k] > ACC_HI)      n_sat[k] = 32'h7FFF_FFFF;
            else if (n_sum[k] < ACC_LO) n_sat[k] = 32'h8000_0000;
            else                        n_sat[k] = n_sum[k][OUT_W-1:0];
        end
        if (r_e4_ctl.vld && r_e4_ctl.last) n_out_vld = 1'b1;
        else if (m_axis_tready)            n_out_vld = 1'b0;
        else                               n_out_vld = r_out_vld;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            for (int k = 0; k < 6; k++) r_acc[k] <= '0;
        end else begin
            r_out_vld <= n_out_vld;
            if (r_e4_ctl.vld) begin
                for (int k = 0; k < 6; k++) r_acc[k] <= r_e4_ctl.last ? '0 : n_sum[k];
            end
        end
        if (r_e4_ctl.vld && r_e4_ctl.last) r_out <= n_sat;
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_out[5], r_out[4], r_out[3], r_out[2], r_out[1], r_out[0]};

    // ---------------------------------------------------------------- checks
    // a finished sum never lands on a result still waiting
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_e4_ctl.vld && r_e4_ctl.last) |-> (!r_out_vld || m_axis_tready))
        else $error("result register overwritten");

    // images of one item are issued only with the pipeline clear of the last one
    a_run_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> !r_inflight)
        else $error("image issued over previous item");

    // the last image ends the run
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_last |=> (r_state == ST_IDLE) && r_inflight)
        else $error("run did not end after last image");

endmodule

// ===== bench/testbench.sv =====
module testbench;
    import pdts_pkg::*;

    // clock and reset
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #4 i_clk = ~i_clk;

    // configuration port
    logic             i_cfg_we = 1'b0;
    logic [IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    // streams
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata = '0;   // off_a [7:0], off_b [15:8], off_c [24:16]
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [191:0] m_axis_tdata;        // t_xx, t_xy, t_xz, t_yy, t_yz, t_zz from the lowest bits

    periodic_dipole_tensor_sum u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // local copy of the lattice and image settings
    logic [47:0] lat_a, lat_b, lat_c;
    logic [8:0]  per_w, per_d;
    logic [11:0] cut;

    logic [191:0] tensor_q[$];
    int  errors = 0;
    int  cycles = 0;
    bit  idle_on = 1'b1;     // random gaps on either side
    bit  hold_req = 1'b0;    // toggled to ask for a long receiver stall
    bit  hold_seen = 1'b0;
    int  hold_off = 0;       // long receiver stall, in cycles

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    function automatic longint floor_sh30(input longint x);
        if (x >= 0) return longint'(longint'(unsigned'(x)) >>> 30);
        return -longint'(64'(-(x + 1)) >> 30) - 1;
    endfunction

    function automatic longint clamp31(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483647) return -64'sd2147483647;
        return v;
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] m0);
        logic [63:0] m, res, bt;
        m = m0; res = 0; bt = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (m >= res + bt) begin
                m = m - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    function automatic longint eff_period(input logic [8:0] v);
        if (v == 0) return 1;
        if (v > MAX_PERIOD) return MAX_PERIOD;
        return longint'(v);
    endfunction

    // lattice sum of the dipole tensor over the in-plane images
    function automatic logic [191:0] dipole_tensor(input logic [7:0] oa, input logic [7:0] ob,
                                                   input logic [8:0] oc);
        longint acc[6];
        longint va[3], vb[3], vc[3], r[3], u[3];
        longint w, d, s, ca, cb, ic, coef, v;
        logic [63:0] r2, m, sq, wi, w2, w3, inv3, mag;
        int h, sh, p, q;
        logic [191:0] res;
        for (int k = 0; k < 6; k++) acc[k] = 0;
        w = eff_period(per_w);
        d = eff_period(per_d);
        s = longint'(cut) / (w < d ? w : d);
        if (s > MAX_IMAGE_RANGE) s = MAX_IMAGE_RANGE;
        ic = longint'($signed(oc));
        for (int k = 0; k < 3; k++) begin
            va[k] = longint'($signed(lat_a[16*k +: 16]));
            vb[k] = longint'($signed(lat_b[16*k +: 16]));
            vc[k] = longint'($signed(lat_c[16*k +: 16]));
        end
        for (longint j = -s; j <= s; j++) begin
            for (longint i = -s; i <= s; i++) begin
                ca = i * w + longint'(oa);
                cb = j * d + longint'(ob);
                r2 = 0;
                for (int k = 0; k < 3; k++) begin
                    r[k] = clamp31(ca * va[k] + cb * vb[k] + ic * vc[k]);
                    mag = r[k] < 0 ? -r[k] : r[k];
                    r2 += mag * mag;
                end
                if (r2 == 0) continue;    // coinciding image
                m = r2; h = 0;
                while (m < (64'd1 << 62)) begin
                    m = m << 2;
                    h++;
                end
                sq = root64(m);
                for (int k = 0; k < 3; k++) begin
                    mag = r[k] < 0 ? -r[k] : r[k];
                    mag = ((mag << h) << 30) / sq;
                    u[k] = r[k] < 0 ? -longint'(mag) : longint'(mag);
                end
                wi = 64'h7FFF_FFFF_FFFF_FFFF / sq;
                w2 = (wi * wi) >> 32;
                w3 = (w2 * wi) >> 32;
                sh = 3 * h - 65;
                if (sh >= 0) inv3 = (sh >= 32) ? 64'd2147483647 : (w3 << sh);
                else inv3 = (-sh >= 64) ? 0 : (w3 >> (-sh));
                if (inv3 > 64'd2147483647) inv3 = 64'd2147483647;   // very close image
                for (int k = 0; k < 6; k++) begin
                    p = PAIR_P[k]; q = PAIR_Q[k];
                    coef = floor_sh30(3 * (u[p] * u[q]));
                    if (p == q) coef -= 64'sd1 << 30;
                    acc[k] += floor_sh30(coef * longint'(inv3));
                end
            end
        end
        for (int k = 0; k < 6; k++) begin
            v = acc[k];
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            res[32*k +: 32] = v[31:0];
        end
        return res;
    endfunction

    // register write, only while nothing is in flight
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [47:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            REG_LATTICE_A: lat_a = val;
            REG_LATTICE_B: lat_b = val;
            REG_LATTICE_C: lat_c = val;
            REG_WIDTH:     per_w = val[8:0];
            REG_DEPTH:     per_d = val[8:0];
            REG_CUTOFF:    cut   = val[11:0];
            default: ;     // unknown index ignored
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic settle();
        while (tensor_q.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    // one input transaction
    task automatic send_offset(input logic [7:0] oa, input logic [7:0] ob,
                               input logic [8:0] oc);
        @(posedge i_clk);
        while (idle_on && $urandom_range(99) < 25) @(posedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, oc, ob, oa};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        tensor_q.push_back(dipole_tensor(oa, ob, oc));
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic send_random(input int n);
        logic [8:0] oc;
        for (int k = 0; k < n; k++) begin
            oc = 9'($urandom_range(510)) - 9'd255;
            send_offset(8'($urandom), 8'($urandom), oc);
        end
    endtask

    // receiver side: random gaps plus an optional long stall
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (hold_req != hold_seen) begin
            hold_seen     <= hold_req;
            hold_off      <= 3000;
            m_axis_tready <= 1'b0;
        end else if (hold_off > 0) begin
            m_axis_tready <= 1'b0;
            hold_off <= hold_off - 1;
        end else begin
            m_axis_tready <= !(idle_on && $urandom_range(99) < 25);
        end
    end

    // result checking against the oldest prediction
    always @(posedge i_clk) begin
        logic [191:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (tensor_q.size() == 0) begin
                report("result with nothing pending");
            end else begin
                want = tensor_q.pop_front();
                for (int k = 0; k < 6; k++)
                    if (want[32*k +: 32] !== m_axis_tdata[32*k +: 32])
                        report($sformatf("element %0d got %h want %h", k,
                                         m_axis_tdata[32*k +: 32], want[32*k +: 32]));
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > 5000000) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic test_reset_lattice();
        send_offset(8'd0, 8'd0, 9'd0);          // coinciding image only
        send_offset(8'd1, 8'd0, 9'd0);
        send_offset(8'd255, 8'd255, 9'h0FF);
        send_offset(8'd0, 8'd0, 9'h101);        // off_c = -255
        send_offset(8'd0, 8'd3, 9'h1FF);
        settle();
    endtask

    task automatic test_periods_and_range();
        write_reg(REG_WIDTH, 48'd0);            // zero period acts as one
        write_reg(REG_DEPTH, 48'd511);          // above the maximum period
        write_reg(REG_CUTOFF, 48'd4095);        // range capped
        send_offset(8'd0, 8'd0, 9'd0);
        send_offset(8'd200, 8'd17, 9'd1);
        settle();
        write_reg(REG_WIDTH, 48'd1);
        write_reg(REG_DEPTH, 48'd1);
        send_offset(8'd0, 8'd0, 9'd0);
        send_offset(8'd255, 8'd0, 9'h1FF);
        settle();
        write_reg(REG_WIDTH, 48'd3);
        write_reg(REG_DEPTH, 48'd5);
        write_reg(REG_CUTOFF, 48'd7);
        send_offset(8'd1, 8'd2, 9'd0);
        send_offset(8'd0, 8'd0, 9'd0);
        settle();
        write_reg(3'd7, 48'hFFFF_FFFF_FFFF);    // unknown index ignored
        write_reg(3'd6, 48'd0);
        send_offset(8'd2, 8'd2, 9'd2);
        settle();
    endtask

    task automatic test_close_and_extreme_lattice();
        write_reg(REG_LATTICE_A, 48'h0000_0000_0001);   // tiny vectors: near images
        write_reg(REG_LATTICE_B, 48'h0000_0001_0000);
        write_reg(REG_LATTICE_C, 48'h0001_0000_0000);
        write_reg(REG_CUTOFF, 48'd0);
        send_offset(8'd1, 8'd0, 9'd0);
        send_offset(8'd1, 8'd1, 9'd1);
        settle();
        write_reg(REG_LATTICE_A, 48'h8000_8000_8000);   // component saturation
        write_reg(REG_LATTICE_B, 48'h7FFF_7FFF_7FFF);
        write_reg(REG_LATTICE_C, 48'hFFFF_FFFF_FFFF);
        send_offset(8'd255, 8'd255, 9'h101);
        send_offset(8'd255, 8'd0, 9'h0FF);
        settle();
    endtask

    task automatic test_random_settings();
        for (int ph = 0; ph < 16; ph++) begin
            write_reg(REG_LATTICE_A, 48'({$urandom, $urandom}));
            write_reg(REG_LATTICE_B, 48'({$urandom, $urandom}));
            write_reg(REG_LATTICE_C, 48'({$urandom, $urandom}));
            write_reg(REG_WIDTH, 48'($urandom_range(511)));
            write_reg(REG_DEPTH, 48'($urandom_range(511)));
            // mostly small ranges keep the run short, a few at the cap
            if (ph % 4 == 3) write_reg(REG_CUTOFF, 48'($urandom));
            else write_reg(REG_CUTOFF, 48'($urandom_range(600)));
            idle_on = (ph != 5);                // one stretch with no gaps
            send_random(95);
            settle();
        end
    endtask

    task automatic test_backpressure();
        write_reg(REG_CUTOFF, 48'd0);
        fork
            hold_req = ~hold_req;
            send_random(20);
        join
        settle();
    endtask

    initial begin
        lat_a = 48'd4096;
        lat_b = 48'd4096 << 16;
        lat_c = 48'd4096 << 32;
        per_w = 9'd32;
        per_d = 9'd32;
        cut   = 12'd0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_lattice();
        test_periods_and_range();
        test_close_and_extreme_lattice();
        test_backpressure();
        test_random_settings();
        settle();
        if (errors == 0 && tensor_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
